### rtl/lspp_pkg.sv
// Shared types and constants of the laser scan point projector.
// Holds field widths, register codes, reset values and the CORDIC atan table.
// No dependencies.
`default_nettype none

package lspp_pkg;

  localparam int BEAM_W       = 12;
  localparam int DIST_W       = 32;
  localparam int PIXEL_W      = 9;
  localparam int ANGLE_W      = 32;
  localparam int XY_W         = 34;  // CORDIC x/y, Q1.30 plus headroom
  localparam int Z_W          = 32;  // CORDIC residual angle
  localparam int TRIG_W       = 18;  // cos/sin in Q2.16
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [XY_W-1:0] TRIG_GAIN_Q30 = 34'sd652032874;

  localparam logic [ANGLE_W-1:0] START_ANGLE_RST = 32'h8000_0000;
  localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST  = 32'h0000_0000;
  localparam logic [DIST_W-1:0]  MIN_RANGE_RST   = 32'd0;
  localparam logic [DIST_W-1:0]  MAX_RANGE_RST   = 32'd229376;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ANGLE = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_MIN_RANGE   = 3'd2,
    CFG_MAX_RANGE   = 3'd3
  } cfg_reg_t;

  // quadrant of the beam angle, east = around zero
  typedef enum logic [1:0] {
    QUAD_E = 2'd0,
    QUAD_N = 2'd1,
    QUAD_W = 2'd2,
    QUAD_S = 2'd3
  } quad_t;

  // sideband that rides along with the CORDIC stages
  typedef struct packed {
    quad_t             quad;
    logic [DIST_W-1:0] rng;
    logic              in_range;
  } beam_tag_t;

  // atan(2^-idx) in binary angle units (one turn = 2^32)
  function automatic logic [Z_W-1:0] atan_unit(input int idx);
    logic [Z_W-1:0] v;
    case (idx)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051E;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2F;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'h0000_A2FA;
      15:      v = 32'h0000_517D;
      16:      v = 32'h0000_28BE;
      17:      v = 32'h0000_145F;
      18:      v = 32'h0000_0A30;
      19:      v = 32'h0000_0518;
      20:      v = 32'h0000_028C;
      21:      v = 32'h0000_0146;
      22:      v = 32'h0000_00A3;
      23:      v = 32'h0000_0051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/lspp_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per register stage.
// Produces cos/sin of the residual angle in Q1.30; depends on lspp_pkg.
`default_nettype none

module lspp_cordic #(
  parameter int STEPS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             adv,
  input  wire logic                             in_valid,
  input  wire logic signed [lspp_pkg::Z_W-1:0]  in_z,
  input  wire lspp_pkg::beam_tag_t              in_tag,
  output logic                                  out_valid,
  output logic signed [lspp_pkg::XY_W-1:0]      out_x,
  output logic signed [lspp_pkg::XY_W-1:0]      out_y,
  output lspp_pkg::beam_tag_t                   out_tag
);

  logic                              vld_r [STEPS];
  logic signed [lspp_pkg::XY_W-1:0]  x_r   [STEPS];
  logic signed [lspp_pkg::XY_W-1:0]  y_r   [STEPS];
  logic signed [lspp_pkg::Z_W-1:0]   z_r   [STEPS-1];
  lspp_pkg::beam_tag_t               tag_r [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic                              vi;
    logic signed [lspp_pkg::XY_W-1:0]  xi, yi, xs, ys, x_nxt, y_nxt;
    logic signed [lspp_pkg::Z_W-1:0]   zi, z_nxt;
    lspp_pkg::beam_tag_t               ti;

    if (i == 0) begin : g_first
      assign vi = in_valid;
      assign xi = lspp_pkg::TRIG_GAIN_Q30;
      assign yi = '0;
      assign zi = in_z;
      assign ti = in_tag;
    end else begin : g_next
      assign vi = vld_r[i-1];
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign ti = tag_r[i-1];
    end

    // arithmetic shift gives floor division by 2^i
    assign xs = xi >>> i;
    assign ys = yi >>> i;

    always_comb begin
      if (!zi[lspp_pkg::Z_W-1]) begin
        x_nxt = xi - ys;
        y_nxt = yi + xs;
        z_nxt = zi - $signed(lspp_pkg::atan_unit(i));
      end else begin
        x_nxt = xi + ys;
        y_nxt = yi - xs;
        z_nxt = zi + $signed(lspp_pkg::atan_unit(i));
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[i]   <= x_nxt;
        y_r[i]   <= y_nxt;
        tag_r[i] <= ti;
      end
    end

    if (i < STEPS - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (adv) begin
          z_r[i] <= z_nxt;
        end
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_x     = x_r[STEPS-1];
  assign out_y     = y_r[STEPS-1];
  assign out_tag   = tag_r[STEPS-1];

endmodule

`default_nettype wire

### rtl/laser_scan_point_projector_top.sv
// Laser scan point projector: lidar beam (index, range) to image pixel.
// Depends on lspp_pkg and lspp_cordic.
//
// Usage: one beam request per cycle on the in_ channel while in_ready is
// high (beam_number, distance in Q16.16 m). Each request gives exactly one
// result on the out_ channel: pixel_x, pixel_y and hit, in request order.
// The cfg_ channel writes start_angle, angle_step, min_range, max_range
// (index 0..3; other indexes are dropped); cfg_ready is always high. The
// user must make writes only while no request is in flight (not enforced).
// Throughput is one beam per cycle while the output is not stalled: every
// stage is a register with a valid bit; the CORDIC has one stage per
// micro-rotation and the range divider one stage per quotient bit, with
// QB = clog2(IMAGE_SIZE+1) quotient bits.
// Stall: when out_valid is high and out_ready low the whole pipeline holds
// and in_ready drops in the same cycle; nothing is dropped or repeated.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults (start_angle -2^31, angle_step 0, min_range 0,
// max_range 3.5 m).
`default_nettype none

module laser_scan_point_projector_top #(
  parameter int IMAGE_SIZE   = 512,
  parameter int BEAM_COUNT   = 4096,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [lspp_pkg::BEAM_W-1:0]        in_beam_number,
  input  wire logic [lspp_pkg::DIST_W-1:0]        in_distance,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [lspp_pkg::PIXEL_W-1:0]            out_pixel_x,
  output logic [lspp_pkg::PIXEL_W-1:0]            out_pixel_y,
  output logic                                    out_hit,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lspp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lspp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int BEAM_W  = lspp_pkg::BEAM_W;
  localparam int DIST_W  = lspp_pkg::DIST_W;
  localparam int ANGLE_W = lspp_pkg::ANGLE_W;
  localparam int XY_W    = lspp_pkg::XY_W;
  localparam int Z_W     = lspp_pkg::Z_W;
  localparam int TRIG_W  = lspp_pkg::TRIG_W;
  localparam int PIXEL_W = lspp_pkg::PIXEL_W;

  localparam int QB      = $clog2(IMAGE_SIZE + 1);   // quotient bits
  localparam int HALF    = IMAGE_SIZE / 2;
  localparam int REC_SH  = 24;
  localparam int REC     = (2**REC_SH + BEAM_COUNT - 1) / BEAM_COUNT;
  localparam int QP_W    = REC_SH + BEAM_W;
  localparam int BC_LO   = BEAM_COUNT % (2**BEAM_W);
  localparam int PH_W    = BEAM_W + ANGLE_W;
  localparam int PRODS_W = DIST_W + TRIG_W + 1;
  localparam int ABS_W   = PRODS_W - 1;
  localparam int MAG_W   = ABS_W + QB;
  localparam int SUM_W   = QB + 1;
  localparam int PIX_W   = (SUM_W > PIXEL_W) ? SUM_W : PIXEL_W;

  typedef struct packed {
    logic       inr;
    logic [1:0] neg;
    logic [1:0] sat;
    logic [1:0] nil;
  } div_flags_t;

  // ---------------------------------------------------------------- config
  logic [ANGLE_W-1:0] start_angle_r, angle_step_r;
  logic [DIST_W-1:0]  min_range_r, max_range_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_angle_r <= lspp_pkg::START_ANGLE_RST;
      angle_step_r  <= lspp_pkg::ANGLE_STEP_RST;
      min_range_r   <= lspp_pkg::MIN_RANGE_RST;
      max_range_r   <= lspp_pkg::MAX_RANGE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        lspp_pkg::CFG_START_ANGLE: start_angle_r <= cfg_data;
        lspp_pkg::CFG_ANGLE_STEP:  angle_step_r  <= cfg_data;
        lspp_pkg::CFG_MIN_RANGE:   min_range_r   <= cfg_data;
        lspp_pkg::CFG_MAX_RANGE:   max_range_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // global pipeline advance
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  // ------------------------------------------- stage 1: beam / BEAM_COUNT
  logic [QP_W-1:0]   qp;
  logic              s1_vld_r, s1_inr_r;
  logic [BEAM_W-1:0] s1_beam_r, s1_q_r;
  logic [DIST_W-1:0] s1_dist_r;

  // reciprocal is exact for a 12-bit dividend
  assign qp = QP_W'(in_beam_number) * QP_W'(REC);

  // ------------------------------------------- stage 2: remainder
  logic [2*BEAM_W-1:0] qb;
  logic                s2_vld_r, s2_inr_r;
  logic [BEAM_W-1:0]   s2_rem_r;
  logic [DIST_W-1:0]   s2_dist_r;

  assign qb = (2*BEAM_W)'(s1_q_r) * (2*BEAM_W)'(BC_LO);

  // ------------------------------------------- stage 3: beam * step
  logic [PH_W-1:0]    ph;
  logic               s3_vld_r, s3_inr_r;
  logic [ANGLE_W-1:0] s3_phase_r;
  logic [DIST_W-1:0]  s3_dist_r;

  assign ph = PH_W'(s2_rem_r) * PH_W'(angle_step_r);

  // ------------------------------------------- stage 4: quadrant split
  logic [ANGLE_W-1:0]  angle, angle_rnd, resid;
  logic [1:0]          quad;
  logic                s4_vld_r;
  logic signed [Z_W-1:0] s4_z_r;
  lspp_pkg::beam_tag_t s4_tag_r;

  assign angle     = start_angle_r + s3_phase_r;
  assign angle_rnd = angle + 32'h2000_0000;
  assign quad      = angle_rnd[ANGLE_W-1 -: 2];
  assign resid     = angle - {quad, 30'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_beam_r <= in_beam_number;
      s1_q_r    <= qp[REC_SH +: BEAM_W];
      s1_dist_r <= in_distance;
      s1_inr_r  <= (in_distance > min_range_r) && (in_distance < max_range_r);

      s2_rem_r  <= s1_beam_r - qb[BEAM_W-1:0];
      s2_dist_r <= s1_dist_r;
      s2_inr_r  <= s1_inr_r;

      s3_phase_r <= ph[ANGLE_W-1:0];
      s3_dist_r  <= s2_dist_r;
      s3_inr_r   <= s2_inr_r;

      s4_z_r            <= $signed(resid);
      s4_tag_r.quad     <= lspp_pkg::quad_t'(quad);
      s4_tag_r.rng      <= s3_dist_r;
      s4_tag_r.in_range <= s3_inr_r;
    end
  end

  // ------------------------------------------- CORDIC
  logic                    cr_vld;
  logic signed [XY_W-1:0]  cr_x, cr_y;
  lspp_pkg::beam_tag_t     cr_tag;

  lspp_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s4_vld_r),
    .in_z      (s4_z_r),
    .in_tag    (s4_tag_r),
    .out_valid (cr_vld),
    .out_x     (cr_x),
    .out_y     (cr_y),
    .out_tag   (cr_tag)
  );

  // ------------------------------------------- quadrant rotate, round Q2.16
  logic signed [XY_W-1:0]   rot_c, rot_s, rnd_c, rnd_s;
  logic                     rt_vld_r, rt_inr_r;
  logic signed [TRIG_W-1:0] rt_trig_r [2];   // 0: cos, 1: sin
  logic [DIST_W-1:0]        rt_dist_r;

  always_comb begin
    case (cr_tag.quad)
      lspp_pkg::QUAD_E: begin rot_c = cr_x;  rot_s = cr_y;  end
      lspp_pkg::QUAD_N: begin rot_c = -cr_y; rot_s = cr_x;  end
      lspp_pkg::QUAD_W: begin rot_c = -cr_x; rot_s = -cr_y; end
      lspp_pkg::QUAD_S: begin rot_c = cr_y;  rot_s = -cr_x; end
      default:          begin rot_c = cr_x;  rot_s = cr_y;  end
    endcase
  end

  assign rnd_c = rot_c + XY_W'(8192);
  assign rnd_s = rot_s + XY_W'(8192);

  // ------------------------------------------- range * trig
  logic signed [DIST_W:0]    dist_s;
  logic signed [PRODS_W-1:0] prod [2];
  logic                      pd_vld_r, pd_inr_r;
  logic [ABS_W-1:0]          pd_abs_r [2];
  logic [1:0]                pd_neg_r;

  // ------------------------------------------- * IMAGE_SIZE
  logic                      mg_vld_r, mg_inr_r;
  logic [MAG_W-1:0]          mg_mag_r [2];
  logic [1:0]                mg_neg_r;

  // ------------------------------------------- saturation check
  logic [MAG_W-1:0]          den_top;
  logic                      st_vld_r;
  logic [MAG_W-1:0]          st_rem_r [2];
  div_flags_t                st_flg_r;
  logic [1:0]                st_sat, st_nil;

  assign dist_s  = $signed({1'b0, rt_dist_r});
  assign den_top = MAG_W'({max_range_r, 17'b0}) << QB;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign prod[l]   = PRODS_W'(dist_s) * PRODS_W'(rt_trig_r[l]);
    assign st_nil[l] = (mg_mag_r[l] == '0);
    assign st_sat[l] = !st_nil[l] && (mg_mag_r[l] >= den_top);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_vld_r <= 1'b0;
      pd_vld_r <= 1'b0;
      mg_vld_r <= 1'b0;
      st_vld_r <= 1'b0;
    end else if (adv) begin
      rt_vld_r <= cr_vld;
      pd_vld_r <= rt_vld_r;
      mg_vld_r <= pd_vld_r;
      st_vld_r <= mg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rt_trig_r[0] <= $signed(rnd_c[14 +: TRIG_W]);
      rt_trig_r[1] <= $signed(rnd_s[14 +: TRIG_W]);
      rt_dist_r    <= cr_tag.rng;
      rt_inr_r     <= cr_tag.in_range;

      for (int l = 0; l < 2; l++) begin
        pd_neg_r[l] <= prod[l][PRODS_W-1];
        pd_abs_r[l] <= prod[l][PRODS_W-1] ? ABS_W'(-prod[l]) : ABS_W'(prod[l]);
        mg_mag_r[l] <= MAG_W'(pd_abs_r[l]) * MAG_W'(IMAGE_SIZE);
        st_rem_r[l] <= mg_mag_r[l];
      end
      pd_inr_r <= rt_inr_r;
      mg_neg_r <= pd_neg_r;
      mg_inr_r <= pd_inr_r;

      st_flg_r.inr <= mg_inr_r;
      st_flg_r.neg <= mg_neg_r;
      st_flg_r.sat <= st_sat;
      st_flg_r.nil <= st_nil;
    end
  end

  // ------------------------------------------- restoring divider, bit a stage
  logic              dv_vld_r [QB];
  logic [QB-1:0]     dv_quo_r [QB][2];
  logic [MAG_W-1:0]  dv_rem_r [QB-1][2];
  div_flags_t        dv_flg_r [QB];

  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int K = QB - 1 - j;
    logic             vj;
    div_flags_t       fj;
    logic [MAG_W-1:0] rj [2];
    logic [QB-1:0]    qj [2];
    logic [MAG_W-1:0] dsh;
    logic [1:0]       ge;

    if (j == 0) begin : g_first
      assign vj = st_vld_r;
      assign fj = st_flg_r;
      for (genvar l = 0; l < 2; l++) begin : g_l
        assign rj[l] = st_rem_r[l];
        assign qj[l] = '0;
      end
    end else begin : g_next
      assign vj = dv_vld_r[j-1];
      assign fj = dv_flg_r[j-1];
      for (genvar l = 0; l < 2; l++) begin : g_l
        assign rj[l] = dv_rem_r[j-1][l];
        assign qj[l] = dv_quo_r[j-1][l];
      end
    end

    assign dsh = MAG_W'({max_range_r, 17'b0}) << K;

    for (genvar l = 0; l < 2; l++) begin : g_cmp
      assign ge[l] = (rj[l] >= dsh);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[j] <= 1'b0;
      end else if (adv) begin
        dv_vld_r[j] <= vj;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_flg_r[j] <= fj;
        for (int l = 0; l < 2; l++) begin
          dv_quo_r[j][l] <= {qj[l][QB-2:0], ge[l]};
        end
      end
    end

    if (j < QB - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          for (int l = 0; l < 2; l++) begin
            dv_rem_r[j][l] <= ge[l] ? rj[l] - dsh : rj[l];
          end
        end
      end
    end
  end

  // ------------------------------------------- offset, clamp, hit
  div_flags_t          fin_flg;
  logic [QB-1:0]       qf     [2];
  logic [SUM_W-1:0]    psum   [2];
  logic [PIX_W-1:0]    pix    [2];
  logic                in_img [2];
  logic [PIXEL_W-1:0]  out_x_r, out_y_r;
  logic                out_hit_r;

  assign fin_flg = dv_flg_r[QB-1];

  for (genvar l = 0; l < 2; l++) begin : g_fin
    always_comb begin
      if (fin_flg.sat[l]) begin
        qf[l] = QB'(IMAGE_SIZE);
      end else if (fin_flg.nil[l]) begin
        qf[l] = '0;
      end else if (dv_quo_r[QB-1][l] > QB'(IMAGE_SIZE)) begin
        qf[l] = QB'(IMAGE_SIZE);
      end else begin
        qf[l] = dv_quo_r[QB-1][l];
      end

      psum[l] = SUM_W'(HALF) + SUM_W'(qf[l]);
      if (!fin_flg.neg[l]) begin
        in_img[l] = psum[l] < SUM_W'(IMAGE_SIZE);
        pix[l]    = in_img[l] ? PIX_W'(psum[l]) : PIX_W'(IMAGE_SIZE - 1);
      end else begin
        in_img[l] = SUM_W'(qf[l]) <= SUM_W'(HALF);
        pix[l]    = in_img[l] ? PIX_W'(HALF) - PIX_W'(qf[l]) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x_r   <= pix[0][PIXEL_W-1:0];
      out_y_r   <= pix[1][PIXEL_W-1:0];
      out_hit_r <= fin_flg.inr && in_img[0] && in_img[1];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_x_r;
  assign out_pixel_y = out_y_r;
  assign out_hit     = out_hit_r;

endmodule

`default_nettype wire

### rtl/lspp_checker.sv
// Port-level assertions for laser_scan_point_projector_top, plus its bind.
// Depends on lspp_pkg for port widths.
`default_nettype none

module lspp_checker #(
  parameter int IMAGE_SIZE = 512
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [lspp_pkg::PIXEL_W-1:0]     out_pixel_x,
  input wire logic [lspp_pkg::PIXEL_W-1:0]     out_pixel_y,
  input wire logic                             out_hit
);

  localparam bit SMALL_IMG = (IMAGE_SIZE <= 512);

  // a stalled result stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_hit))
    else $error("stalled result changed");

  // pipeline freezes as a whole on output stall
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

  // clamped coordinates land on the image (checked when IMAGE_SIZE <= 512)
  a_pixel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && SMALL_IMG |->
      (out_pixel_x < IMAGE_SIZE) && (out_pixel_y < IMAGE_SIZE))
    else $error("pixel coordinate outside image");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind laser_scan_point_projector_top lspp_checker #(
  .IMAGE_SIZE (IMAGE_SIZE)
) u_lspp_checker (.*);

`default_nettype wire

### tb/tb_laser_scan_point_projector_top.sv
// Testbench for laser_scan_point_projector_top: beams go in, pixel coordinates come out.
// A scoreboard class predicts each result and compares it in order, under random flow control.
// Depends on lspp_pkg and the projector RTL.
`default_nettype none

module tb_laser_scan_point_projector_top;
  import lspp_pkg::*;

  localparam int IMAGE_SIZE   = 512;
  localparam int BEAM_COUNT   = 4096;
  localparam int CORDIC_STEPS = 16;
  localparam int PIPE_LATENCY = CORDIC_STEPS + $clog2(IMAGE_SIZE + 1) + 9;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_BEAMS  = 200;
  localparam int LONG_HOLD    = 4 * PIPE_LATENCY;

  // atan(2^-i) in binary angle units, one turn = 2^32
  localparam logic [31:0] ATAN_BAU [ATAN_ENTRIES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

  typedef struct packed {
    logic [PIXEL_W-1:0] x;
    logic [PIXEL_W-1:0] y;
    logic               hit;
  } pixel_t;

  class beam_scoreboard;
    logic [ANGLE_W-1:0] start_angle;
    logic [ANGLE_W-1:0] angle_inc;
    logic [DIST_W-1:0]  min_range;
    logic [DIST_W-1:0]  upper_range;
    pixel_t             pixel_q[$];
    int                 mismatches;
    int                 checked;
    int                 hits;

    function new();
      start_angle = START_ANGLE_RST;
      angle_inc   = ANGLE_STEP_RST;
      min_range   = MIN_RANGE_RST;
      upper_range = MAX_RANGE_RST;
      mismatches  = 0;
      checked     = 0;
      hits        = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_START_ANGLE: start_angle = data;
        CFG_ANGLE_STEP:  angle_inc   = data;
        CFG_MIN_RANGE:   min_range   = data;
        CFG_MAX_RANGE:   upper_range = data;
        default: ;  // unknown index: dropped by the block
      endcase
    endfunction

    // cos/sin of a binary angle, Q2.16
    function void trig_of(input logic [ANGLE_W-1:0] angle, output longint cos16,
                          output longint sin16);
      logic [31:0] shifted;
      logic [31:0] resid;
      quad_t       quad;
      longint      z, x, y, xs, ys, c, s;
      shifted = angle + 32'h2000_0000;
      quad    = quad_t'(shifted[31:30]);
      resid   = angle - {shifted[31:30], 30'd0};
      z       = longint'($signed(resid));
      x       = longint'(TRIG_GAIN_Q30);
      y       = 0;
      for (int i = 0; i < CORDIC_STEPS && i < ATAN_ENTRIES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - longint'({32'd0, ATAN_BAU[i]});
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + longint'({32'd0, ATAN_BAU[i]});
        end
      end
      case (quad)
        QUAD_E: begin c = x;  s = y;  end
        QUAD_N: begin c = -y; s = x;  end
        QUAD_W: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      cos16 = (c + 8192) >>> 14;
      sin16 = (s + 8192) >>> 14;
    endfunction

    // center plus offset truncated toward zero, offset magnitude capped at IMAGE_SIZE
    function longint project_axis(input logic [DIST_W-1:0] rng, input longint trig);
      longint          prod;
      longint unsigned mag, den, quo;
      prod = longint'({32'd0, rng}) * trig;
      mag  = (prod < 0) ? -prod : prod;
      mag  = mag * IMAGE_SIZE;
      den  = {32'd0, upper_range} << 17;
      if (den == 0)
        quo = (mag != 0) ? IMAGE_SIZE : 0;
      else
        quo = mag / den;
      if (quo > IMAGE_SIZE)
        quo = IMAGE_SIZE;
      return IMAGE_SIZE / 2 + ((prod < 0) ? -longint'(quo) : longint'(quo));
    endfunction

    function logic [PIXEL_W-1:0] clamp_pixel(input longint v);
      longint clamped;
      clamped = (v < 0) ? 0 : ((v > IMAGE_SIZE - 1) ? IMAGE_SIZE - 1 : v);
      return clamped[PIXEL_W-1:0];
    endfunction

    function void note_request(logic [BEAM_W-1:0] beam, logic [DIST_W-1:0] rng);
      logic [31:0] beam_idx;
      logic [31:0] angle;
      longint      c16, s16, px, py;
      pixel_t      exp_pix;
      beam_idx = {20'd0, beam} % BEAM_COUNT;
      angle    = start_angle + beam_idx * angle_inc;
      trig_of(angle, c16, s16);
      px = project_axis(rng, c16);
      py = project_axis(rng, s16);
      exp_pix.x   = clamp_pixel(px);
      exp_pix.y   = clamp_pixel(py);
      exp_pix.hit = (rng > min_range) && (rng < upper_range) &&
                    px >= 0 && px < IMAGE_SIZE && py >= 0 && py < IMAGE_SIZE;
      if (exp_pix.hit)
        hits++;
      pixel_q.insert(pixel_q.size(), exp_pix);
    endfunction

    function void check_result(logic [PIXEL_W-1:0] x, logic [PIXEL_W-1:0] y, logic hit);
      pixel_t exp_pix;
      checked++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d hit=%0b", $time, x, y, hit);
        mismatches++;
        return;
      end
      exp_pix = pixel_q.pop_front();
      if (x !== exp_pix.x) begin
        $display("%0t: pixel_x expected %0d got %0d", $time, exp_pix.x, x);
        mismatches++;
      end
      if (y !== exp_pix.y) begin
        $display("%0t: pixel_y expected %0d got %0d", $time, exp_pix.y, y);
        mismatches++;
      end
      if (hit !== exp_pix.hit) begin
        $display("%0t: hit expected %0b got %0b", $time, exp_pix.hit, hit);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pixel_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [BEAM_W-1:0]     in_beam_number;
  logic [DIST_W-1:0]     in_distance;
  logic                  out_valid;
  logic                  out_ready;
  logic [PIXEL_W-1:0]    out_pixel_x;
  logic [PIXEL_W-1:0]    out_pixel_y;
  logic                  out_hit;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  beam_scoreboard sb;
  bit             send_idle_en;
  bit             recv_idle_en;
  bit             long_hold_req;
  int             beams_sent;
  int             settings_used;

  laser_scan_point_projector_top #(
    .IMAGE_SIZE  (IMAGE_SIZE),
    .BEAM_COUNT  (BEAM_COUNT),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_beam_number(in_beam_number),
    .in_distance   (in_distance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_x   (out_pixel_x),
    .out_pixel_y   (out_pixel_y),
    .out_hit       (out_hit),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic send_beam(input logic [BEAM_W-1:0] beam, input logic [DIST_W-1:0] rng);
    int gap;
    gap = send_idle_en ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_beam_number <= beam;
    in_distance    <= rng;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(beam, rng);
    beams_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] sa, input logic [31:0] inc,
                                input logic [31:0] lo, input logic [31:0] hi);
    write_reg(CFG_START_ANGLE, sa);
    write_reg(CFG_ANGLE_STEP, inc);
    write_reg(CFG_MIN_RANGE, lo);
    write_reg(CFG_MAX_RANGE, hi);
    settings_used++;
  endtask

  // stop offering requests and wait for the pipeline to empty
  task automatic drain(input int limit);
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.outstanding() > 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // ranges biased toward the window and its edges
  function automatic logic [DIST_W-1:0] pick_distance();
    logic [31:0] lo, hi;
    lo = sb.min_range;
    hi = sb.upper_range;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return '1;
      2: return $urandom_range(0, 3);
      3: return hi + $urandom_range(0, 4) - 2;
      4: return lo + $urandom_range(0, 4) - 2;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int gap;
      gap = recv_idle_en ? $urandom_range(0, 4) : 0;
      if (long_hold_req) begin
        gap += LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_result(out_pixel_x, out_pixel_y, out_hit);
    end
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [31:0] inc;
    logic [31:0] hi;
    sb             = new();
    send_idle_en   = 1'b1;
    recv_idle_en   = 1'b1;
    long_hold_req  = 1'b0;
    beams_sent     = 0;
    settings_used  = 1;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_beam_number <= '0;
    in_distance    <= '0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: zero, infinite, edges of the range window
    send_beam(0, 0);
    send_beam(0, '1);
    send_beam(4095, MAX_RANGE_RST - 1);
    send_beam(17, MAX_RANGE_RST);
    send_beam(5, 32'h0001_0000);
    drain(10_000);

    // quarter-turn steps: one beam per quadrant, min edge, axis at full range
    apply_settings(32'h0000_0000, 32'h4000_0000, 32'h0000_8000, 32'h0004_0000);
    for (int q = 0; q < 4; q++)
      send_beam(q, 32'h0003_0000);
    send_beam(4095, 32'h0000_8000);
    send_beam(4, 32'h0000_8001);
    send_beam(0, 32'h0003_FFFF);
    drain(10_000);

    // zero max range: nothing passes, nonzero offsets saturate
    write_reg(CFG_MAX_RANGE, 32'd0);
    send_beam(0, 0);
    send_beam(1, 5);
    send_beam(2, '1);
    drain(10_000);

    // all-ones bounds, extreme angles, and a write to an unknown index
    apply_settings(32'h7FFF_FFFF, 32'h8000_0000, '1, '1);
    write_reg(CFG_IDX_W'($urandom_range(4, 7)), $urandom());
    send_beam(0, 32'hFFFF_FFFE);
    send_beam(4095, '1);
    send_beam(1, 32'h8000_0000);
    drain(10_000);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      inc = $urandom_range(0, 1 << 21);
      if ($urandom_range(0, 1))
        inc = -inc;
      hi = $urandom_range(1 << 16, 1 << 24);
      case (ph)
        1: apply_settings(32'h7FFF_FFFF, 32'h8000_0000, '0, '1);
        3: apply_settings(32'h8000_0000, 32'h7FFF_FFFF, '0, 32'd1);
        5: apply_settings($urandom(), $urandom(), $urandom_range(0, 1 << 16), '0);
        default: apply_settings($urandom(), inc, $urandom_range(0, hi >> 3), hi);
      endcase
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(4, 7)), $urandom());
      send_idle_en = (ph % 3 != 2);
      recv_idle_en = (ph % 4 != 3);
      // back-pressure: receiver stalls long enough to fill the pipeline
      if (ph == 2 || ph == 6)
        long_hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEAMS; n++)
        send_beam($urandom_range(0, 4095), pick_distance());
      drain(20_000);
    end

    drain(20_000);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (sb.outstanding() > 0) begin
      $display("%0t: %0d results never arrived", $time, sb.outstanding());
      sb.mismatches += sb.outstanding();
    end
    $display("Sent %0d beams under %0d register settings; %0d results checked, %0d hits.",
             beams_sent, settings_used, sb.checked, sb.hits);
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/lspp_pkg.sv
rtl/lspp_cordic.sv
rtl/laser_scan_point_projector_top.sv
rtl/lspp_checker.sv
tb/tb_laser_scan_point_projector_top.sv
